// ===== hdl/fmp_pkg.sv =====
`timescale 1ns / 1ps

package fmp_pkg;

   // Parser phases, one-hot
   typedef enum logic [4:0] {
      PH_HEAD1 = 5'b00001,
      PH_HEAD2 = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_SUM   = 5'b10000
   } fmp_phase_type;

   // Event reported with every transfer
   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_HEADER_ERR = 3'd1,
      EV_CHECK_ERR  = 3'd2,
      EV_HANDSHAKE  = 3'd3,
      EV_HOST_CMD   = 3'd4,
      EV_LASER_ACK  = 3'd5,
      EV_LASER_STAT = 3'd6,
      EV_IGNORED    = 3'd7
   } fmp_event_type;

   // Payload store write request
   typedef struct packed {
      logic       en;
      logic [7:0] pos;
      logic [7:0] data;
   } fmp_store_wr_type;

   localparam logic [7:0]  SYNC_FIRST     = 8'h55;
   localparam logic [7:0]  SYNC_SECOND    = 8'hAA;
   localparam logic [7:0]  HANDSHAKE_LEN  = 8'd1;
   localparam logic [7:0]  HANDSHAKE_CODE = 8'd1;
   localparam logic [7:0]  ACK_LEN        = 8'd2;
   localparam logic [7:0]  HOST_CMD_LEN   = 8'd12;
   localparam logic [7:0]  LASER_STAT_LEN = 8'd22;
   localparam logic [16:0] HOST_BIAS      = 17'd1750;
   localparam logic [16:0] LASER_BIAS     = 17'd1500;

   // Payload positions of the captured fields
   localparam logic [7:0] POS_B0      = 8'd0;
   localparam logic [7:0] POS_W01_HI  = 8'd1;
   localparam logic [7:0] POS_W23_HI  = 8'd3;
   localparam logic [7:0] POS_B4      = 8'd4;
   localparam logic [7:0] POS_B5      = 8'd5;
   localparam logic [7:0] POS_W14_HI  = 8'd15;
   localparam logic [7:0] POS_W16_HI  = 8'd17;

endpackage

// ===== hdl/fmp_channels.sv =====
`timescale 1ns / 1ps

interface fmp_req_if;
   import fmp_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fmp_rsp_if;
   import fmp_pkg::*;

   logic               valid;
   logic               ready;
   logic [2:0]         event_res;
   logic signed [16:0] pitch_cmd;
   logic signed [16:0] yaw_cmd;
   logic [7:0]         capture_cmd;
   logic [7:0]         mode_cmd;
   logic [7:0]         laser_state;
   logic [7:0]         laser_pattern;
   logic               receiving;
   logic               handshake_done;
   logic               laser_ok;
   logic [31:0]        error_count;

   modport source (output valid, output event_res, output pitch_cmd, output yaw_cmd,
                   output capture_cmd, output mode_cmd, output laser_state,
                   output laser_pattern, output receiving, output handshake_done,
                   output laser_ok, output error_count, input ready);
   modport sink (input valid, input event_res, input pitch_cmd, input yaw_cmd,
                 input capture_cmd, input mode_cmd, input laser_state,
                 input laser_pattern, input receiving, input handshake_done,
                 input laser_ok, input error_count, output ready);
endinterface

// ===== hdl/framed_message_parser.sv =====
`timescale 1ns / 1ps

// Byte-serial frame parser. Frames are 0x55, 0xAA, a length byte, the payload
// and a checksum (low 8 bits of the payload sum plus the length).
// req_bus: one received byte per transfer. rsp_bus: exactly one result per
// byte: the event for that byte and every held command, status, flag and the
// error count as they stand after the byte.
// csr_wr_en / csr_wr_data select the peer kind (0 host link, 1 laser link);
// write it only while no result is pending.
// The result of a byte is valid in the cycle after its transfer. Throughput
// is one byte per cycle while rsp_bus is not stalled; the only per-byte loop
// is the update of the frame counters plus one payload memory write, and
// payload words are assembled from the memory's registered read port.
// While rsp_bus is stalled the result holds and req_bus.ready drops; a result
// taken in the same cycle frees the output register for the next byte.
// Reset (synchronous) returns the parser to waiting for 0x55, clears all held
// values, flags and the error count, and selects the host link. The payload
// memory needs no clearing: every field is read from entries written in the
// same frame.
module framed_message_parser #(
   parameter int PAYLOAD_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   fmp_req_if.sink    req_bus,
   fmp_rsp_if.source  rsp_bus
);
   import fmp_pkg::*;

   logic               accept;
   logic [7:0]         rx;
   logic [7:0]         rd_data;
   logic [7:0]         rd_pos;
   fmp_store_wr_type   store_wr;

   logic               peer_kind_ff;
   logic               rsp_valid_ff;
   fmp_event_type      event_ff, event_in;
   fmp_phase_type      phase_ff, phase_in;
   logic [7:0]         frame_len_ff, frame_len_in;
   logic [7:0]         taken_ff, taken_in;
   logic [7:0]         sum_ff, sum_in;

   logic               b0_one_ff, b0_one_in;
   logic               b1_zero_ff, b1_zero_in;
   logic [15:0]        word01_ff, word01_in;
   logic [15:0]        word23_ff, word23_in;
   logic [7:0]         byte4_ff, byte4_in;
   logic [7:0]         byte5_ff, byte5_in;
   logic [15:0]        word14_ff, word14_in;
   logic [15:0]        word16_ff, word16_in;

   logic signed [16:0] pitch_ff, pitch_in;
   logic signed [16:0] yaw_ff, yaw_in;
   logic [7:0]         capture_ff, capture_in;
   logic [7:0]         mode_ff, mode_in;
   logic [7:0]         work_ff, work_in;
   logic [7:0]         code_ff, code_in;
   logic               recv_ff, recv_in;
   logic               shake_ff, shake_in;
   logic               laser_ff, laser_in;
   logic [31:0]        errors_ff, errors_in;

   // Accept a byte whenever the result register is empty or being drained
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rx            = req_bus.rx_byte;

   // Store payload bytes; read back the most recently written position
   assign store_wr.en   = accept && (phase_ff == PH_DATA);
   assign store_wr.pos  = taken_ff;
   assign store_wr.data = rx;
   assign rd_pos        = store_wr.en ? taken_ff : (taken_ff - 8'd1);

   fmp_payload_store #(
      .DEPTH (PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_pos  (rd_pos),
      .rd_data (rd_data)
   );

   // Advance the parser by one byte
   always_comb begin
      event_in     = EV_NONE;
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      taken_in     = taken_ff;
      sum_in       = sum_ff;
      b0_one_in    = b0_one_ff;
      b1_zero_in   = b1_zero_ff;
      word01_in    = word01_ff;
      word23_in    = word23_ff;
      byte4_in     = byte4_ff;
      byte5_in     = byte5_ff;
      word14_in    = word14_ff;
      word16_in    = word16_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      capture_in   = capture_ff;
      mode_in      = mode_ff;
      work_in      = work_ff;
      code_in      = code_ff;
      recv_in      = recv_ff;
      shake_in     = shake_ff;
      laser_in     = laser_ff;
      errors_in    = errors_ff;

      case (phase_ff)
         PH_HEAD1: begin
            if (rx == SYNC_FIRST) begin
               recv_in  = 1'b1;
               phase_in = PH_HEAD2;
            end else begin
               errors_in = errors_ff + 32'd1;
               event_in  = EV_HEADER_ERR;
            end
         end
         PH_HEAD2: begin
            if (rx == SYNC_SECOND) begin
               phase_in = PH_LEN;
            end else begin
               phase_in  = PH_HEAD1;
               errors_in = errors_ff + 32'd1;
               event_in  = EV_HEADER_ERR;
            end
         end
         PH_LEN: begin
            frame_len_in = rx;
            taken_in     = 8'd0;
            sum_in       = 8'd0;
            phase_in     = PH_DATA;
         end
         PH_DATA: begin
            // a zero-length frame still takes one byte, left out of the sum
            if (frame_len_ff != 8'd0) begin
               sum_in = sum_ff + rx;
            end
            taken_in = taken_ff + 8'd1;
            if (taken_in >= frame_len_ff) begin
               phase_in = PH_SUM;
            end
            // capture fields; word low bytes come from the store
            case (taken_ff)
               POS_B0:     b0_one_in = (rx == HANDSHAKE_CODE);
               POS_W01_HI: begin
                  word01_in  = {rx, rd_data};
                  b1_zero_in = (rx == 8'd0);
               end
               POS_W23_HI: word23_in = {rx, rd_data};
               POS_B4:     byte4_in  = rx;
               POS_B5:     byte5_in  = rx;
               POS_W14_HI: word14_in = {rx, rd_data};
               POS_W16_HI: word16_in = {rx, rd_data};
               default:    ;
            endcase
         end
         PH_SUM: begin
            if ((sum_ff + frame_len_ff) == rx) begin
               recv_in  = 1'b0;
               event_in = EV_IGNORED;
               if (!peer_kind_ff) begin
                  if (frame_len_ff == HANDSHAKE_LEN && b0_one_ff) begin
                     shake_in = 1'b1;
                     event_in = EV_HANDSHAKE;
                  end else if (frame_len_ff == HOST_CMD_LEN) begin
                     pitch_in   = signed'({1'b0, word01_ff} - HOST_BIAS);
                     yaw_in     = signed'({1'b0, word23_ff} - HOST_BIAS);
                     capture_in = byte4_ff;
                     mode_in    = byte5_ff;
                     event_in   = EV_HOST_CMD;
                  end
               end else begin
                  if (frame_len_ff == ACK_LEN && b1_zero_ff) begin
                     laser_in = 1'b1;
                     event_in = EV_LASER_ACK;
                  end else if (frame_len_ff == LASER_STAT_LEN) begin
                     laser_in = 1'b1;
                     work_in  = byte4_ff;
                     code_in  = byte5_ff;
                     pitch_in = signed'(LASER_BIAS - {1'b0, word14_ff});
                     yaw_in   = signed'(LASER_BIAS - {1'b0, word16_ff});
                     event_in = EV_LASER_STAT;
                  end
               end
            end else begin
               errors_in = errors_ff + 32'd1;
               event_in  = EV_CHECK_ERR;
            end
            frame_len_in = 8'd0;
            taken_in     = 8'd0;
            sum_in       = 8'd0;
            phase_in     = PH_HEAD1;
         end
         default: begin
            phase_in = PH_HEAD1;
         end
      endcase
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         peer_kind_ff <= 1'b0;
      end else if (csr_wr_en) begin
         peer_kind_ff <= csr_wr_data;
      end
   end

   // Track the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Update parser state and held values on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         event_ff     <= EV_NONE;
         phase_ff     <= PH_HEAD1;
         frame_len_ff <= 8'd0;
         taken_ff     <= 8'd0;
         sum_ff       <= 8'd0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         capture_ff   <= 8'd0;
         mode_ff      <= 8'd0;
         work_ff      <= 8'd0;
         code_ff      <= 8'd0;
         recv_ff      <= 1'b0;
         shake_ff     <= 1'b0;
         laser_ff     <= 1'b0;
         errors_ff    <= 32'd0;
      end else if (accept) begin
         event_ff     <= event_in;
         phase_ff     <= phase_in;
         frame_len_ff <= frame_len_in;
         taken_ff     <= taken_in;
         sum_ff       <= sum_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         capture_ff   <= capture_in;
         mode_ff      <= mode_in;
         work_ff      <= work_in;
         code_ff      <= code_in;
         recv_ff      <= recv_in;
         shake_ff     <= shake_in;
         laser_ff     <= laser_in;
         errors_ff    <= errors_in;
      end
   end

   // Capture frame fields
   always_ff @(posedge clock) begin
      if (accept) begin
         b0_one_ff  <= b0_one_in;
         b1_zero_ff <= b1_zero_in;
         word01_ff  <= word01_in;
         word23_ff  <= word23_in;
         byte4_ff   <= byte4_in;
         byte5_ff   <= byte5_in;
         word14_ff  <= word14_in;
         word16_ff  <= word16_in;
      end
   end

   // Drive the result channel
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.event_res      = event_ff;
   assign rsp_bus.pitch_cmd      = pitch_ff;
   assign rsp_bus.yaw_cmd        = yaw_ff;
   assign rsp_bus.capture_cmd    = capture_ff;
   assign rsp_bus.mode_cmd       = mode_ff;
   assign rsp_bus.laser_state    = work_ff;
   assign rsp_bus.laser_pattern  = code_ff;
   assign rsp_bus.receiving      = recv_ff;
   assign rsp_bus.handshake_done = shake_ff;
   assign rsp_bus.laser_ok       = laser_ff;
   assign rsp_bus.error_count    = errors_ff;

endmodule

// ===== hdl/fmp_payload_store.sv =====
`timescale 1ns / 1ps

module fmp_payload_store #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  fmp_pkg::fmp_store_wr_type wr,
   input  logic [7:0]               rd_pos,
   output logic [7:0]               rd_data
);
   import fmp_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0]       payload_mem_ff [DEPTH];
   logic [7:0]       rd_data_ff;
   logic             wr_hit;
   logic             rd_hit;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   // Only positions inside the store are kept
   assign wr_hit = wr.en && ({1'b0, wr.pos} < 9'(DEPTH));
   assign rd_hit = {1'b0, rd_pos} < 9'(DEPTH);
   assign wr_idx = wr.pos[IDX_W-1:0];
   assign rd_idx = rd_pos[IDX_W-1:0];

   // Write the received byte
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         payload_mem_ff[wr_idx] <= wr.data;
      end
   end

   // Register the read, forward a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (wr_hit && (wr.pos == rd_pos)) begin
         rd_data_ff <= wr.data;
      end else if (rd_hit) begin
         rd_data_ff <= payload_mem_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
